[hdl/bmprle_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the BMP run-length decoder.
// Used by the core, the output buffer, the top level and the checker.
package bmprle_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_ROW_BYTES   = 2'd1;
  localparam logic [1:0] REG_IMAGE_BYTES = 2'd2;

  localparam logic        MODE_RST        = 1'b0;
  localparam logic [15:0] ROW_BYTES_RST   = 16'd4;
  localparam logic [23:0] IMAGE_BYTES_RST = 24'd4;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [1:0] EV_WRITE = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_CLIP  = 2'd2;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_VALUE,
    PH_ESCAPE,
    PH_DX,
    PH_DY,
    PH_LITERAL,
    PH_PAD
  } phase_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  pixel_value;
    logic [7:0]  pixel_count;
    logic        start_low;
    logic [15:0] column;
    logic [15:0] row;
  } res_t;

endpackage

[hdl/bmprle_core.sv]
`timescale 1ns / 1ps
// Parse machine and position datapath of the BMP run-length decoder.
// Depends on bmprle_pkg; produces at most one descriptor per accepted byte.
module bmprle_core #(
  parameter int COORD_BITS = bmprle_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  input  logic               mode,
  input  logic [15:0]        row_bytes,
  input  logic [23:0]        image_bytes,
  output logic               res_valid,
  output bmprle_pkg::res_t   res
);

  localparam int PW = COORD_BITS + 16;
  localparam int CW = (COORD_BITS > 16) ? COORD_BITS : 16;

  bmprle_pkg::phase_t phase, phase_next, e_phase;
  logic [7:0]            pending_count, pending_next, e_pending;
  logic [7:0]            literal_left, literal_next, e_literal, literal_after;
  logic                  pad_pending, pad_next, e_pad;
  logic [COORD_BITS-1:0] cur_row, row_next, e_row;
  logic [COORD_BITS-1:0] cur_col, col_next, e_col;
  logic                  low_phase, low_next, e_low;
  logic [7:0]            delta_x, delta_next, e_delta;
  logic                  stopped, stopped_next, e_stopped;
  logic [PW-1:0]         prod;

  logic [7:0]            nib_n, adv_n, allowed8, w4_cnt;
  logic [PW-1:0]         addr;
  logic                  in_bound;
  logic [23:0]           diff;
  logic [COORD_BITS:0]   pos;
  logic [CW-1:0]         avail, col_sum8;
  logic                  clip;
  logic [8:0]            b_plus1;
  logic [COORD_BITS+15:0] row_ext, col_ext;

  // A frame start clears position and parse state before the byte is parsed.
  assign e_phase   = frame_start ? bmprle_pkg::PH_COUNT : phase;
  assign e_pending = frame_start ? 8'd0 : pending_count;
  assign e_literal = frame_start ? 8'd0 : literal_left;
  assign e_pad     = frame_start ? 1'b0 : pad_pending;
  assign e_row     = frame_start ? '0 : cur_row;
  assign e_col     = frame_start ? '0 : cur_col;
  assign e_low     = frame_start ? 1'b0 : low_phase;
  assign e_delta   = frame_start ? 8'd0 : delta_x;
  assign e_stopped = frame_start ? 1'b0 : stopped;

  // The row base product is refreshed every cycle. Any other row change is at
  // least two bytes ahead of the next write, and a frame start, which can be
  // followed by a write on the very next byte, clears the product with the row.
  always_ff @(posedge clk) begin
    if (accept && frame_start) begin
      prod <= '0;
    end else begin
      prod <= PW'(cur_row) * PW'(row_bytes);
    end
  end

  assign nib_n = (e_phase == bmprle_pkg::PH_VALUE) ? e_pending :
                 ((e_literal < 8'd2) ? e_literal : 8'd2);
  assign adv_n = (e_phase == bmprle_pkg::PH_DY) ? e_delta : nib_n;

  assign addr     = prod + PW'(e_col);
  assign in_bound = addr < PW'(image_bytes);
  assign diff     = image_bytes - addr[23:0];
  assign allowed8 = {diff[6:0], 1'b0} - {7'd0, e_low};

  always_comb begin
    if (!in_bound) begin
      w4_cnt = 8'd0;
    end else if (diff[23:7] != 17'd0) begin
      w4_cnt = nib_n;
    end else begin
      w4_cnt = (nib_n < allowed8) ? nib_n : allowed8;
    end
  end

  assign pos = {e_col, e_low} + (COORD_BITS + 1)'(adv_n);

  assign avail    = (CW'(e_col) < CW'(row_bytes)) ? (CW'(row_bytes) - CW'(e_col)) : '0;
  assign clip     = CW'(e_pending) > avail;
  assign col_sum8 = CW'(e_col) + (clip ? avail : CW'(e_pending));

  assign b_plus1 = {1'b0, data_byte} + 9'd1;

  assign literal_after = mode ? (e_literal - nib_n) : (e_literal - 8'd1);

  always_comb begin
    phase_next = e_phase;
    if (!e_stopped) begin
      unique case (e_phase)
        bmprle_pkg::PH_COUNT: begin
          phase_next = (data_byte != 8'd0) ? bmprle_pkg::PH_VALUE : bmprle_pkg::PH_ESCAPE;
        end
        bmprle_pkg::PH_VALUE: begin
          phase_next = bmprle_pkg::PH_COUNT;
        end
        bmprle_pkg::PH_ESCAPE: begin
          if (data_byte == bmprle_pkg::ESC_EOL || data_byte == bmprle_pkg::ESC_EOB) begin
            phase_next = bmprle_pkg::PH_COUNT;
          end else if (data_byte == bmprle_pkg::ESC_DELTA) begin
            phase_next = bmprle_pkg::PH_DX;
          end else begin
            phase_next = bmprle_pkg::PH_LITERAL;
          end
        end
        bmprle_pkg::PH_DX: begin
          phase_next = bmprle_pkg::PH_DY;
        end
        bmprle_pkg::PH_DY: begin
          phase_next = bmprle_pkg::PH_COUNT;
        end
        bmprle_pkg::PH_LITERAL: begin
          if (literal_after == 8'd0) begin
            phase_next = e_pad ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_COUNT;
          end
        end
        default: begin
          phase_next = bmprle_pkg::PH_COUNT;
        end
      endcase
    end
  end

  assign row_ext = {16'd0, e_row};
  assign col_ext = {16'd0, e_col};

  always_comb begin
    pending_next    = e_pending;
    literal_next    = e_literal;
    pad_next        = e_pad;
    row_next        = e_row;
    col_next        = e_col;
    low_next        = e_low;
    delta_next      = e_delta;
    stopped_next    = e_stopped;
    res_valid       = 1'b0;
    res.row         = row_ext[15:0];
    res.column      = col_ext[15:0];
    res.start_low   = 1'b0;
    res.pixel_count = 8'd0;
    res.pixel_value = data_byte;
    res.event_res   = bmprle_pkg::EV_WRITE;
    if (!e_stopped) begin
      unique case (e_phase)
        bmprle_pkg::PH_COUNT: begin
          if (data_byte != 8'd0) begin
            pending_next = data_byte;
          end
        end
        bmprle_pkg::PH_VALUE: begin
          res_valid = 1'b1;
          if (mode) begin
            res.start_low   = e_low;
            res.pixel_count = w4_cnt;
            col_next        = pos[COORD_BITS:1];
            low_next        = pos[0];
          end else if (clip) begin
            res.pixel_count = avail[7:0];
            res.event_res   = bmprle_pkg::EV_CLIP;
            col_next        = col_sum8[COORD_BITS-1:0];
            stopped_next    = 1'b1;
          end else begin
            res.pixel_count = e_pending;
            col_next        = col_sum8[COORD_BITS-1:0];
          end
        end
        bmprle_pkg::PH_ESCAPE: begin
          if (data_byte == bmprle_pkg::ESC_EOL) begin
            row_next = e_row + COORD_BITS'(1);
            col_next = '0;
            low_next = 1'b0;
          end else if (data_byte == bmprle_pkg::ESC_EOB) begin
            res_valid       = 1'b1;
            res.pixel_value = 8'd0;
            res.event_res   = bmprle_pkg::EV_END;
            stopped_next    = 1'b1;
          end else if (data_byte != bmprle_pkg::ESC_DELTA) begin
            literal_next = data_byte;
            pad_next     = mode ? b_plus1[1] : data_byte[0];
          end
        end
        bmprle_pkg::PH_DX: begin
          delta_next = data_byte;
        end
        bmprle_pkg::PH_DY: begin
          if (mode) begin
            col_next = pos[COORD_BITS:1];
            low_next = pos[0];
          end else begin
            col_next = e_col + COORD_BITS'(e_delta);
          end
          row_next = e_row + COORD_BITS'(data_byte);
        end
        bmprle_pkg::PH_LITERAL: begin
          res_valid    = 1'b1;
          literal_next = literal_after;
          if (mode) begin
            res.start_low   = e_low;
            res.pixel_count = w4_cnt;
            col_next        = pos[COORD_BITS:1];
            low_next        = pos[0];
          end else begin
            res.pixel_count = 8'd1;
            col_next        = e_col + COORD_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bmprle_pkg::PH_COUNT;
      pending_count <= 8'd0;
      literal_left  <= 8'd0;
      pad_pending   <= 1'b0;
      cur_row       <= '0;
      cur_col       <= '0;
      low_phase     <= 1'b0;
      delta_x       <= 8'd0;
      stopped       <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      pending_count <= pending_next;
      literal_left  <= literal_next;
      pad_pending   <= pad_next;
      cur_row       <= row_next;
      cur_col       <= col_next;
      low_phase     <= low_next;
      delta_x       <= delta_next;
      stopped       <= stopped_next;
    end
  end

endmodule

[hdl/bmprle_obuf.sv]
`timescale 1ns / 1ps
// Two-entry output buffer: result register plus skid register.
// Depends on bmprle_pkg for the descriptor type.
module bmprle_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bmprle_pkg::res_t push_data,
  output logic             space,
  output logic             out_valid,
  output bmprle_pkg::res_t out_data,
  input  logic             out_ready
);

  logic             skid_valid;
  bmprle_pkg::res_t skid_data;
  logic             pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

[hdl/bmp_rle_decoder_top.sv]
`timescale 1ns / 1ps
// The decoder takes one compressed byte per cycle and returns the pixel-write
// or event descriptor that the byte causes, if any, through a two-entry output
// buffer. Input is held off only while both buffer entries are full, and in the
// cycle after reset or after any configuration write, while the row base
// product (row times row_bytes) in its register is brought up to date.
// Top level of the BMP run-length decoder; depends on bmprle_pkg, bmprle_core
// and bmprle_obuf.
module bmp_rle_decoder_top #(
  parameter int COORD_BITS = bmprle_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // row, column, start_low, pixel_count, pixel_value
  output logic [1:0]  m_axis_tuser,   // event_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic             mode;
  logic [15:0]      row_bytes;
  logic [23:0]      image_bytes;
  logic             stale;
  logic             accept;
  logic             space;
  logic             res_valid;
  bmprle_pkg::res_t res;
  bmprle_pkg::res_t out_data;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = space && !stale;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= bmprle_pkg::MODE_RST;
      row_bytes   <= bmprle_pkg::ROW_BYTES_RST;
      image_bytes <= bmprle_pkg::IMAGE_BYTES_RST;
      stale       <= 1'b1;
    end else begin
      stale <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bmprle_pkg::REG_MODE:        mode        <= cfg_data[0];
          bmprle_pkg::REG_ROW_BYTES:   row_bytes   <= cfg_data[15:0];
          bmprle_pkg::REG_IMAGE_BYTES: image_bytes <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  bmprle_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .mode        (mode),
    .row_bytes   (row_bytes),
    .image_bytes (image_bytes),
    .res_valid   (res_valid),
    .res         (res)
  );

  bmprle_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, out_data.pixel_value, out_data.pixel_count,
                         out_data.start_low, out_data.column, out_data.row};
  assign m_axis_tuser = out_data.event_res;

endmodule

[hdl/bmprle_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the BMP run-length decoder, bound to the top level.
// Depends on bmprle_pkg for the event codes.
module bmprle_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Output changed while stalled.");

  a_new_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("Result appeared without an input transfer.");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == bmprle_pkg::EV_WRITE ||
                       m_axis_tuser == bmprle_pkg::EV_END ||
                       m_axis_tuser == bmprle_pkg::EV_CLIP))
    else $error("Unknown event code.");

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == bmprle_pkg::EV_END |-> m_axis_tdata[48:32] == 17'd0)
    else $error("End of bitmap carries pixel data.");

  a_clip_byte_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == bmprle_pkg::EV_CLIP |-> !m_axis_tdata[32])
    else $error("Clipped write has a low nibble start.");

endmodule

bind bmp_rle_decoder_top bmprle_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
